// ===== src/toroidal_life_automaton_step_unit_macros.svh =====
// Assertion macros shared by the RTL of the toroidal life step unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TOROIDAL_LIFE_AUTOMATON_STEP_UNIT_MACROS_SVH
`define TOROIDAL_LIFE_AUTOMATON_STEP_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TLAS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tlas assertion failed");

// The consequence must hold in the same cycle as the antecedent.
`define TLAS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlas assertion failed");

`endif

// ===== src/tlas_pkg.sv =====
// Types and constants of the toroidal life step unit.
// No dependencies.
package tlas_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_GEN,
        S_DONE
    } state_t;

    localparam logic [2:0] CFG_SURVIVE_MIN  = 3'd0;
    localparam logic [2:0] CFG_SURVIVE_MAX  = 3'd1;
    localparam logic [2:0] CFG_BIRTH_MIN    = 3'd2;
    localparam logic [2:0] CFG_BIRTH_MAX    = 3'd3;
    localparam logic [2:0] CFG_BIRTH_CHANCE = 3'd4;
    localparam logic [2:0] CFG_GRID_COLS    = 3'd5;
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd6;
    localparam logic [2:0] CFG_RNG_SEED     = 3'd7;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;
    // Floor of 2^19/100, so the quotient estimate is low by at most one.
    localparam logic [12:0] RECIP_100  = 13'd5242;

    localparam logic [2:0] PH_CENTER = 3'd0;
    localparam logic [2:0] PH_UP     = 3'd1;
    localparam logic [2:0] PH_DOWN   = 3'd2;
    localparam logic [2:0] PH_LEFT   = 3'd3;
    localparam logic [2:0] PH_RIGHT  = 3'd4;
    localparam logic [2:0] PH_RULE   = 3'd5;
    localparam logic [2:0] PH_WRITE  = 3'd6;

    function automatic logic [15:0] lfsr_advance(input logic [15:0] v);
        return (v >> 1) ^ (v[0] ? LFSR_TAPS : 16'd0);
    endfunction

endpackage

// ===== src/tlas_bank.sv =====
// One-bit cell memory with one write port and one registered read port.
// No dependencies.
module tlas_bank #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/toroidal_life_automaton_step_unit.sv =====
// Toroidal life step unit: two cell banks, one live and one for the next generation.
// Write cell, read cell, run and clear each answer with one result; clear first sweeps both banks.
// Run: each cell of a generation passes through the phases center, up, down, left, right,
// rule and write, with the five reads of each cell through the single read port of the live bank.
// After reset a sweep over all MAX_COLS*MAX_ROWS addresses empties both banks; in_ready is low.
// Depends on tlas_pkg, tlas_bank and the macros header.
`include "toroidal_life_automaton_step_unit_macros.svh"

module toroidal_life_automaton_step_unit
    import tlas_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [5:0]  col,
    input  logic [5:0]  row,
    input  logic        cell_in,
    input  logic [7:0]  generations,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        cell_out,
    output logic [31:0] generation_count,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int XW    = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int YW    = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    logic [2:0]  survive_min_reg, survive_max_reg, birth_min_reg, birth_max_reg;
    logic [6:0]  birth_chance_reg, grid_cols_reg, grid_rows_reg;
    logic [15:0] rng_seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_min_reg  <= 3'd2;
            survive_max_reg  <= 3'd3;
            birth_min_reg    <= 3'd3;
            birth_max_reg    <= 3'd3;
            birth_chance_reg <= 7'd100;
            grid_cols_reg    <= 7'd64;
            grid_rows_reg    <= 7'd64;
            rng_seed_reg     <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SURVIVE_MIN:  survive_min_reg  <= cfg_data[2:0];
                CFG_SURVIVE_MAX:  survive_max_reg  <= cfg_data[2:0];
                CFG_BIRTH_MIN:    birth_min_reg    <= cfg_data[2:0];
                CFG_BIRTH_MAX:    birth_max_reg    <= cfg_data[2:0];
                CFG_BIRTH_CHANCE: birth_chance_reg <= cfg_data[6:0];
                CFG_GRID_COLS:    grid_cols_reg    <= cfg_data[6:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[6:0];
                CFG_RNG_SEED:     rng_seed_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic [XW-1:0] cols_act;
    logic [YW-1:0] rows_act;

    always_comb
    begin
        if (grid_cols_reg == 7'd0)
            cols_act = XW'(1);
        else if (XW'(grid_cols_reg) > XW'(MAX_COLS))
            cols_act = XW'(MAX_COLS);
        else
            cols_act = XW'(grid_cols_reg);
        if (grid_rows_reg == 7'd0)
            rows_act = YW'(1);
        else if (YW'(grid_rows_reg) > YW'(MAX_ROWS))
            rows_act = YW'(MAX_ROWS);
        else
            rows_act = YW'(grid_rows_reg);
    end

    state_t        state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          sweep_reply_reg, sweep_reply_next;
    logic          bank_reg, bank_next;
    logic [31:0]   steps_reg, steps_next;
    logic [15:0]   lfsr_reg, lfsr_next;
    logic [7:0]    gens_reg, gens_next;
    logic          inside_reg, inside_next;
    logic          alive_reg, alive_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          draw_reg, draw_next;
    logic          keep_reg, keep_next;
    logic [28:0]   prod_reg, prod_next;
    logic [7:0]    limit_reg, limit_next;
    logic          result_reg, result_next;
    logic          out_valid_reg, out_valid_next;
    logic          cell_out_reg, cell_out_next;
    logic [31:0]   count_out_reg, count_out_next;

    logic          we0, we1, wdata;
    logic [AW-1:0] waddr, raddr;
    logic          rd0, rd1, rd_live;

    logic [XW-1:0] x_left, x_right;
    logic [YW-1:0] y_up, y_down;
    logic [2:0]    n_total;
    logic          in_area;
    logic [AW-1:0] in_addr, center_addr;
    logic [9:0]    quot;
    logic [15:0]   rem_raw, rem;
    logic          born;

    tlas_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
        .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
    );
    tlas_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
        .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
    );

    assign rd_live     = bank_reg ? rd1 : rd0;
    assign x_left      = (x_reg == '0) ? cols_act - XW'(1) : x_reg - XW'(1);
    assign x_right     = (x_reg == cols_act - XW'(1)) ? '0 : x_reg + XW'(1);
    assign y_up        = (y_reg == '0) ? rows_act - YW'(1) : y_reg - YW'(1);
    assign y_down      = (y_reg == rows_act - YW'(1)) ? '0 : y_reg + YW'(1);
    assign n_total     = cnt_reg + 3'(rd_live);
    assign in_area     = (XW'(col) < cols_act) && (YW'(row) < rows_act);
    assign in_addr     = cell_addr(RW'(row), CW'(col));
    assign center_addr = cell_addr(y_reg[RW-1:0], x_reg[CW-1:0]);
    assign quot        = prod_reg[28:19];
    assign rem_raw     = lfsr_reg - 16'(quot) * 16'd100;
    assign rem         = (rem_raw >= 16'd100) ? rem_raw - 16'd100 : rem_raw;
    assign born        = (rem < 16'(limit_reg));

    always_comb
    begin
        case (phase_reg)
            PH_UP:    raddr = cell_addr(y_up[RW-1:0], x_reg[CW-1:0]);
            PH_DOWN:  raddr = cell_addr(y_down[RW-1:0], x_reg[CW-1:0]);
            PH_LEFT:  raddr = cell_addr(y_reg[RW-1:0], x_left[CW-1:0]);
            PH_RIGHT: raddr = cell_addr(y_reg[RW-1:0], x_right[CW-1:0]);
            default:  raddr = (state_reg == S_GEN) ? center_addr : in_addr;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        sweep_next       = sweep_reg;
        sweep_reply_next = sweep_reply_reg;
        bank_next        = bank_reg;
        steps_next       = steps_reg;
        lfsr_next        = lfsr_reg;
        gens_next        = gens_reg;
        inside_next      = inside_reg;
        alive_next       = alive_reg;
        cnt_next         = cnt_reg;
        draw_next        = draw_reg;
        keep_next        = keep_reg;
        prod_next        = prod_reg;
        limit_next       = limit_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cell_out_next    = cell_out_reg;
        count_out_next   = count_out_reg;
        in_ready         = 1'b0;
        we0              = 1'b0;
        we1              = 1'b0;
        waddr            = center_addr;
        wdata            = 1'b0;

        case (state_reg)
            S_SWEEP:
            begin
                we0        = 1'b1;
                we1        = 1'b1;
                waddr      = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = sweep_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                result_next = 1'b0;
                if (in_valid)
                begin
                    case (opcode_t'(opcode))
                        OP_WRITE:
                        begin
                            waddr      = in_addr;
                            wdata      = cell_in;
                            we0        = in_area && !bank_reg;
                            we1        = in_area && bank_reg;
                            state_next = S_DONE;
                        end
                        OP_READ:
                        begin
                            inside_next = in_area;
                            state_next  = S_READ;
                        end
                        OP_RUN:
                        begin
                            gens_next  = generations;
                            phase_next = PH_CENTER;
                            x_next     = '0;
                            y_next     = '0;
                            if (generations == 8'd0)
                                state_next = S_DONE;
                            else
                            begin
                                steps_next = steps_reg + 32'd1;
                                state_next = S_GEN;
                            end
                        end
                        default:
                        begin
                            bank_next        = 1'b0;
                            steps_next       = '0;
                            lfsr_next        = (rng_seed_reg == 16'd0) ? 16'd1 : rng_seed_reg;
                            sweep_next       = '0;
                            sweep_reply_next = 1'b1;
                            state_next       = S_SWEEP;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                result_next = inside_reg && rd_live;
                state_next  = S_DONE;
            end
            S_GEN:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    PH_UP:
                    begin
                        alive_next = rd_live;
                        cnt_next   = '0;
                    end
                    PH_DOWN, PH_LEFT, PH_RIGHT:
                        cnt_next = n_total;
                    PH_RULE:
                    begin
                        draw_next  = !alive_reg && (n_total >= birth_min_reg)
                                     && (n_total <= birth_max_reg);
                        keep_next  = alive_reg && !((n_total < survive_min_reg)
                                     || (n_total > survive_max_reg));
                        limit_next = 8'(birth_chance_reg)
                                     + 8'(3'(n_total - birth_min_reg)) * 8'd5;
                        if (draw_next)
                        begin
                            lfsr_next = lfsr_advance(lfsr_reg);
                            prod_next = 29'(lfsr_next) * 29'(RECIP_100);
                        end
                    end
                    PH_WRITE:
                    begin
                        wdata      = draw_reg ? born : keep_reg;
                        we0        = bank_reg;
                        we1        = !bank_reg;
                        phase_next = PH_CENTER;
                        if (y_reg == rows_act - YW'(1))
                        begin
                            y_next = '0;
                            if (x_reg == cols_act - XW'(1))
                            begin
                                x_next    = '0;
                                bank_next = !bank_reg;
                                gens_next = gens_reg - 8'd1;
                                if (gens_reg == 8'd1)
                                    state_next = S_DONE;
                                else
                                    steps_next = steps_reg + 32'd1;
                            end
                            else
                                x_next = x_reg + XW'(1);
                        end
                        else
                            y_next = y_reg + YW'(1);
                    end
                    default:
                        ;
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    cell_out_next    = result_reg;
                    count_out_next   = steps_reg;
                    sweep_reply_next = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            phase_reg       <= PH_CENTER;
            x_reg           <= '0;
            y_reg           <= '0;
            sweep_reg       <= '0;
            sweep_reply_reg <= 1'b0;
            bank_reg        <= 1'b0;
            steps_reg       <= '0;
            lfsr_reg        <= SEED_RESET;
            gens_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            sweep_reg       <= sweep_next;
            sweep_reply_reg <= sweep_reply_next;
            bank_reg        <= bank_next;
            steps_reg       <= steps_next;
            lfsr_reg        <= lfsr_next;
            gens_reg        <= gens_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg    <= inside_next;
        alive_reg     <= alive_next;
        cnt_reg       <= cnt_next;
        draw_reg      <= draw_next;
        keep_reg      <= keep_next;
        prod_reg      <= prod_next;
        limit_reg     <= limit_next;
        result_reg    <= result_next;
        cell_out_reg  <= cell_out_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign cell_out         = cell_out_reg;
    assign generation_count = count_out_reg;

    `TLAS_ASSERT_IMPL(a_gen_writes_other_bank, state_reg == S_GEN, !(bank_reg ? we1 : we0))
    `TLAS_ASSERT_IMPL(a_scan_in_area, state_reg == S_GEN,
        (x_reg < cols_act) && (y_reg < rows_act))
    `TLAS_ASSERT_ALWAYS(a_lfsr_nonzero, lfsr_reg != 16'd0)

endmodule

// ===== dv/tb_toroidal_life_automaton_step_unit.sv =====
// Testbench for the toroidal life step unit: directed table, then random phases per setting.
// Results are checked against an in-bench predictor of the two-bank grid, LFSR and counter.
// Depends on tlas_pkg and the toroidal_life_automaton_step_unit RTL.
module tb_toroidal_life_automaton_step_unit;
    import tlas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        opcode_t     op;
        logic [5:0]  c;
        logic [5:0]  r;
        logic        v;
        logic [7:0]  g;
        bit          typed;
        logic        e_cell;
        logic [31:0] e_count;
    } vector_t;

    typedef struct {
        logic        cell_val;
        logic [31:0] count;
    } outcome_t;

    typedef struct {
        logic [15:0] val [8];
    } setting_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    opcode_t     opcode;
    logic [5:0]  col;
    logic [5:0]  row;
    logic        cell_in;
    logic [7:0]  generations;
    logic        out_valid;
    logic        out_ready;
    logic        cell_out;
    logic [31:0] generation_count;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    bit          grid_bank [2][GRID_W*GRID_H];
    bit          live_sel;
    logic [31:0] step_total;
    logic [15:0] birth_lfsr;
    int unsigned rule_smin, rule_smax, rule_bmin, rule_bmax, rule_chance;
    int unsigned size_cols, size_rows;
    logic [15:0] seed_reg;

    outcome_t    pending_results [$];
    int          error_count = 0;
    int          stall_cycles = 0;
    bit          quiet = 0;
    int          runs_done = 0;
    int          gens_done = 0;
    int          items_sent = 0;

    toroidal_life_automaton_step_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .col(col), .row(row), .cell_in(cell_in),
        .generations(generations),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_out(cell_out), .generation_count(generation_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned span_cols();
        int unsigned n;
        n = size_cols;
        if (n == 0) n = 1;
        if (n > GRID_W) n = GRID_W;
        return n;
    endfunction

    function automatic int unsigned span_rows();
        int unsigned n;
        n = size_rows;
        if (n == 0) n = 1;
        if (n > GRID_H) n = GRID_H;
        return n;
    endfunction

    function automatic void wipe_grid();
        for (int i = 0; i < GRID_W*GRID_H; i++)
        begin
            grid_bank[0][i] = 1'b0;
            grid_bank[1][i] = 1'b0;
        end
        live_sel = 1'b0;
        step_total = '0;
    endfunction

    function automatic void evolve_once();
        int unsigned nc, nr, up, dn, lf, rt, n, lim;
        bit alive, nxt;
        nc = span_cols();
        nr = span_rows();
        step_total = step_total + 1;
        for (int unsigned x = 0; x < nc; x++)
        begin
            for (int unsigned y = 0; y < nr; y++)
            begin
                up = (y == 0) ? nr - 1 : y - 1;
                dn = (y == nr - 1) ? 0 : y + 1;
                lf = (x == 0) ? nc - 1 : x - 1;
                rt = (x == nc - 1) ? 0 : x + 1;
                alive = grid_bank[live_sel][y*GRID_W + x];
                n = grid_bank[live_sel][up*GRID_W + x] + grid_bank[live_sel][dn*GRID_W + x]
                  + grid_bank[live_sel][y*GRID_W + lf] + grid_bank[live_sel][y*GRID_W + rt];
                if (!alive && n >= rule_bmin && n <= rule_bmax)
                begin
                    lim = rule_chance + 5 * (n - rule_bmin);
                    birth_lfsr = (birth_lfsr >> 1) ^ (birth_lfsr[0] ? LFSR_TAPS : 16'd0);
                    nxt = ((birth_lfsr % 100) < lim);
                end
                else if (alive && (n < rule_smin || n > rule_smax))
                    nxt = 1'b0;
                else
                    nxt = alive;
                grid_bank[!live_sel][y*GRID_W + x] = nxt;
            end
        end
        live_sel = !live_sel;
    endfunction

    function automatic outcome_t apply_item(input opcode_t op, input logic [5:0] c,
                                            input logic [5:0] r, input logic v,
                                            input logic [7:0] g);
        outcome_t res;
        bit in_area;
        in_area = (c < span_cols()) && (r < span_rows());
        res.cell_val = 1'b0;
        case (op)
            OP_WRITE: if (in_area) grid_bank[live_sel][r*GRID_W + c] = v;
            OP_READ:  if (in_area) res.cell_val = grid_bank[live_sel][r*GRID_W + c];
            OP_RUN:
            begin
                for (int i = 0; i < g; i++) evolve_once();
                runs_done++;
                gens_done += g;
            end
            default:
            begin
                wipe_grid();
                birth_lfsr = (seed_reg == 16'd0) ? 16'd1 : seed_reg;
            end
        endcase
        res.count = step_total;
        return res;
    endfunction

    task automatic send_item(input vector_t t);
        outcome_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= t.op;
        col <= t.c;
        row <= t.r;
        cell_in <= t.v;
        generations <= t.g;
        do @(posedge clk); while (!in_ready);
        res = apply_item(t.op, t.c, t.r, t.v, t.g);
        if (t.typed)
        begin
            res.cell_val = t.e_cell;
            res.count = t.e_count;
        end
        pending_results.push_back(res);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_setting(input setting_t s);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= s.val[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        rule_smin = s.val[CFG_SURVIVE_MIN] & 7;
        rule_smax = s.val[CFG_SURVIVE_MAX] & 7;
        rule_bmin = s.val[CFG_BIRTH_MIN] & 7;
        rule_bmax = s.val[CFG_BIRTH_MAX] & 7;
        rule_chance = s.val[CFG_BIRTH_CHANCE] & 127;
        size_cols = s.val[CFG_GRID_COLS] & 127;
        size_rows = s.val[CFG_GRID_ROWS] & 127;
        seed_reg = s.val[CFG_RNG_SEED];
        @(negedge clk);
    endtask

    function automatic vector_t random_item();
        vector_t t;
        int unsigned pick, area;
        pick = $urandom_range(0, 99);
        t.typed = 0;
        t.e_cell = 0;
        t.e_count = 0;
        t.v = 1'($urandom_range(0, 1));
        if (pick < 40) t.op = OP_WRITE;
        else if (pick < 72) t.op = OP_READ;
        else if (pick < 93) t.op = OP_RUN;
        else t.op = OP_CLEAR;
        if ($urandom_range(0, 4) == 0)
        begin
            t.c = 6'($urandom_range(0, 63));
            t.r = 6'($urandom_range(0, 63));
        end
        else
        begin
            t.c = 6'($urandom_range(0, span_cols() - 1));
            t.r = 6'($urandom_range(0, span_rows() - 1));
        end
        t.g = 8'($urandom_range(0, 255));
        area = span_cols() * span_rows();
        if (area * t.g > 3000) t.g = t.g % 8'd16;
        return t;
    endfunction

    vector_t directed [] = '{
        '{OP_READ,  6'd0,  6'd0,  1'b0, 8'd0, 1, 1'b0, 32'd0},
        '{OP_WRITE, 6'd63, 6'd63, 1'b1, 8'd0, 1, 1'b0, 32'd0},
        '{OP_READ,  6'd63, 6'd63, 1'b0, 8'd0, 1, 1'b1, 32'd0},
        '{OP_WRITE, 6'd0,  6'd0,  1'b1, 8'd0, 1, 1'b0, 32'd0},
        '{OP_WRITE, 6'd1,  6'd0,  1'b1, 8'd0, 1, 1'b0, 32'd0},
        '{OP_WRITE, 6'd0,  6'd1,  1'b1, 8'd0, 1, 1'b0, 32'd0},
        '{OP_WRITE, 6'd63, 6'd0,  1'b1, 8'd0, 1, 1'b0, 32'd0},
        '{OP_RUN,   6'd0,  6'd0,  1'b0, 8'd0, 1, 1'b0, 32'd0},
        '{OP_RUN,   6'd0,  6'd0,  1'b0, 8'd1, 0, 1'b0, 32'd0},
        '{OP_READ,  6'd0,  6'd0,  1'b0, 8'd0, 0, 1'b0, 32'd0},
        '{OP_READ,  6'd63, 6'd63, 1'b0, 8'd0, 0, 1'b0, 32'd0},
        '{OP_READ,  6'd1,  6'd1,  1'b0, 8'd0, 0, 1'b0, 32'd0},
        '{OP_WRITE, 6'd5,  6'd9,  1'b0, 8'd0, 0, 1'b0, 32'd0},
        '{OP_CLEAR, 6'd0,  6'd0,  1'b0, 8'd0, 1, 1'b0, 32'd0},
        '{OP_READ,  6'd0,  6'd0,  1'b0, 8'd0, 1, 1'b0, 32'd0}
    };

    setting_t phases [] = '{
        '{'{16'd2, 16'd3, 16'd1, 16'd2, 16'd60,  16'd8,   16'd8, 16'hACE1}},
        '{'{16'd0, 16'd4, 16'd0, 16'd4, 16'd127, 16'd5,   16'd7, 16'd0}},
        '{'{16'd4, 16'd0, 16'd4, 16'd0, 16'd0,   16'd0,   16'd0, 16'd65535}},
        '{'{16'd1, 16'd2, 16'd2, 16'd4, 16'd30,  16'd100, 16'd1, 16'd1}},
        '{'{16'd3, 16'd4, 16'd1, 16'd3, 16'd90,  16'd3,   16'd6, 16'd12345}},
        '{'{16'd1, 16'd3, 16'd0, 16'd2, 16'd50,  16'd2,   16'd2, 16'd7}}
    };

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        col = '0;
        row = '0;
        cell_in = 1'b0;
        generations = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rule_smin = 2; rule_smax = 3; rule_bmin = 3; rule_bmax = 3;
        rule_chance = 100; size_cols = 64; size_rows = 64;
        seed_reg = SEED_RESET;
        birth_lfsr = SEED_RESET;
        wipe_grid();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i]) send_item(directed[i]);
        foreach (phases[p])
        begin
            load_setting(phases[p]);
            send_item('{OP_CLEAR, 6'd0, 6'd0, 1'b0, 8'd0, 0, 1'b0, 32'd0});
            if (phases[p].val[CFG_GRID_COLS] == 16'd0)
                send_item('{OP_RUN, 6'd0, 6'd0, 1'b0, 8'd255, 0, 1'b0, 32'd0});
            for (int k = 0; k < 22; k++)
            begin
                if (p == phases.size() - 1 && k >= 8) quiet = 1;
                send_item(random_item());
            end
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d transactions over %0d rule settings,",
                 items_sent, phases.size() + 1);
        $display("with %0d runs totaling %0d generations.", runs_done, gens_done);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: cell_out %0d generation_count %0d",
                       cell_out, generation_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_out !== want.cell_val)
                begin
                    $error("cell_out expected %0d actual %0d", want.cell_val, cell_out);
                    error_count++;
                end
                if (generation_count !== want.count)
                begin
                    $error("generation_count expected %0d actual %0d",
                           want.count, generation_count);
                    error_count++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
